@@ design/pdcc_pkg.sv @@
// Package: payload types, codes and the CRC-32 byte update for the PSDU deaggregator.
`default_nettype none
package pdcc_pkg;

   localparam int unsigned LEN_W   = 22;
   localparam int unsigned SUB_W   = 14;
   localparam int unsigned CRC_W   = 32;

   localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;
   localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0] CRC_RESIDUE = 32'h2144_DF1C;

   localparam logic [1:0] FMT_LEGACY = 2'd0;
   localparam logic [1:0] FMT_HT     = 2'd1;
   localparam logic [1:0] FMT_VHT    = 2'd2;

   localparam logic [1:0] STATUS_GOOD = 2'd0;
   localparam logic [1:0] STATUS_BAD  = 2'd1;
   localparam logic [1:0] STATUS_RATE = 2'd2;

   localparam logic [3:0] LEGACY_RATE_LIMIT = 4'd8;
   localparam logic [LEN_W:0] DELIM_BYTES = 23'd4;

   typedef struct packed {
      logic [7:0]       data_byte;
      logic             first_byte;
      logic [LEN_W-1:0] psdu_length;
      logic [1:0]       frame_format;
      logic [3:0]       rate_index;
      logic             aggregated;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [LEN_W-1:0] frame_length;
      logic [LEN_W-1:0] payload_offset;
      logic             last_of_psdu;
   } rsp_type;

   // reflected CRC-32, one byte
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

@@ design/psdu_deaggregation_crc_check.sv @@
// Top level: A-MPDU delimiter parser and CRC-32 FCS check over a PSDU byte stream.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_ready  | req_data (pdcc_pkg::req_type), one PSDU byte
//   rsp     | out | rsp_valid/rsp_ready  | rsp_data (pdcc_pkg::rsp_type), zero or one per byte
//
// One byte per cycle while req_ready is high: the byte-wide CRC update, counters
// and delimiter checks sit between the parse state registers and the result register.
// A result is written to the output register as the byte that causes it is accepted.
// req_ready drops only while a result sits in the output register and rsp_ready is low.
// Synchronous reset returns the parser to idle and empties the output register.
`default_nettype none
module psdu_deaggregation_crc_check (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire pdcc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output pdcc_pkg::rsp_type     rsp_data
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_WHOLE = 2'd1;
   localparam logic [1:0] PH_DELIM = 2'd2;
   localparam logic [1:0] PH_BODY  = 2'd3;

   localparam int unsigned LW = pdcc_pkg::LEN_W;
   localparam int unsigned SW = pdcc_pkg::SUB_W;

   logic [1:0]    phase_ff, phase_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [LW-1:0] len_ff, len_in;
   logic [1:0]    fmt_ff, fmt_in;
   logic [3:0]    rate_ff, rate_in;
   logic [1:0]    didx_ff, didx_in;
   logic [15:0]   dbits_ff, dbits_in;
   logic [SW-1:0] remain_ff, remain_in;
   logic          eof_ff, eof_in;
   logic [31:0]   crc_ff, crc_in;

   logic              rsp_valid_ff, rsp_valid_in;
   pdcc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          accept;
   logic          emit;
   logic          go;
   logic          last;
   logic [1:0]    idx;
   logic [SW-1:0] dlen;
   logic [LW:0]   next_pos;
   logic [LW+1:0] body_end;

   // end of subframe: does parsing of this PSDU stop here
   function automatic logic sub_last(input logic eof, input logic [LW:0] nxt,
                                     input logic [LW-1:0] len);
      logic [LW:0] len_x;
      len_x = {1'b0, len};
      return eof || (nxt > len_x) || ((len_x - nxt) < pdcc_pkg::DELIM_BYTES);
   endfunction

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      fmt_in      = fmt_ff;
      rate_in     = rate_ff;
      didx_in     = didx_ff;
      dbits_in    = dbits_ff;
      remain_in   = remain_ff;
      eof_in      = eof_ff;
      crc_in      = crc_ff;
      emit        = 1'b0;
      go          = 1'b0;
      last        = 1'b0;
      idx         = didx_ff;
      dlen        = '0;
      next_pos    = '0;
      body_end    = '0;
      rsp_data_in = rsp_data_ff;

      if (req_data.first_byte) begin
         len_in    = req_data.psdu_length;
         fmt_in    = req_data.frame_format;
         rate_in   = req_data.rate_index;
         pos_in    = '0;
         crc_in    = pdcc_pkg::CRC_PRESET;
         eof_in    = 1'b0;
         didx_in   = '0;
         dbits_in  = '0;
         remain_in = '0;
         if (req_data.frame_format == pdcc_pkg::FMT_VHT) begin
            if ({1'b0, req_data.psdu_length} < pdcc_pkg::DELIM_BYTES) begin
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_DELIM;
               go       = 1'b1;
            end
         end else if (req_data.aggregated) begin
            phase_in = PH_IDLE;
         end else if (req_data.psdu_length == '0) begin
            phase_in    = PH_IDLE;
            emit        = 1'b1;
            rsp_data_in = '{status: pdcc_pkg::STATUS_BAD, frame_length: '0,
                            payload_offset: '0, last_of_psdu: 1'b1};
         end else begin
            phase_in = PH_WHOLE;
            go       = 1'b1;
         end
      end else if (phase_ff != PH_IDLE) begin
         pos_in = pos_ff + 1'b1;
         go     = 1'b1;
      end

      next_pos = {1'b0, pos_in} + 1'b1;
      idx      = didx_in;

      if (go) begin
         unique case (phase_in)
            PH_WHOLE: begin
               crc_in = pdcc_pkg::crc_byte(crc_in, req_data.data_byte);
               if (next_pos >= {1'b0, len_in}) begin
                  phase_in = PH_IDLE;
                  emit     = 1'b1;
                  rsp_data_in.frame_length   = len_in;
                  rsp_data_in.payload_offset = '0;
                  rsp_data_in.last_of_psdu   = 1'b1;
                  if (~crc_in != pdcc_pkg::CRC_RESIDUE) begin
                     rsp_data_in.status = pdcc_pkg::STATUS_BAD;
                  end else if ((fmt_in == pdcc_pkg::FMT_LEGACY &&
                                rate_in < pdcc_pkg::LEGACY_RATE_LIMIT) ||
                               fmt_in == pdcc_pkg::FMT_HT) begin
                     rsp_data_in.status = pdcc_pkg::STATUS_GOOD;
                  end else begin
                     rsp_data_in.status = pdcc_pkg::STATUS_RATE;
                  end
               end
            end
            PH_DELIM: begin
               unique case (idx)
                  2'd0:    dbits_in[7:0]  = req_data.data_byte;
                  2'd1:    dbits_in[15:8] = req_data.data_byte;
                  default: dbits_in       = dbits_in;
               endcase
               didx_in = idx + 1'b1;
               if (idx == 2'd3) begin
                  dlen     = {dbits_in[3:2], dbits_in[15:4]};
                  eof_in   = dbits_in[0];
                  body_end = {1'b0, next_pos} + {{(LW+2-SW){1'b0}}, dlen};
                  if (body_end > {2'b00, len_in}) begin
                     phase_in = PH_IDLE;
                  end else begin
                     crc_in = pdcc_pkg::CRC_PRESET;
                     if (dlen == '0) begin
                        last        = sub_last(eof_in, next_pos, len_in);
                        emit        = 1'b1;
                        rsp_data_in = '{status: pdcc_pkg::STATUS_BAD, frame_length: '0,
                                        payload_offset: next_pos[LW-1:0],
                                        last_of_psdu: last};
                        phase_in    = last ? PH_IDLE : PH_DELIM;
                        if (!last) begin
                           didx_in  = '0;
                           dbits_in = '0;
                        end
                     end else begin
                        remain_in = dlen;
                        phase_in  = PH_BODY;
                     end
                  end
               end
            end
            PH_BODY: begin
               crc_in    = pdcc_pkg::crc_byte(crc_in, req_data.data_byte);
               remain_in = remain_in - 1'b1;
               if (remain_in == '0) begin
                  dlen        = {dbits_in[3:2], dbits_in[15:4]};
                  last        = sub_last(eof_in, next_pos, len_in);
                  emit        = 1'b1;
                  rsp_data_in.status = (~crc_in == pdcc_pkg::CRC_RESIDUE) ?
                                       pdcc_pkg::STATUS_GOOD : pdcc_pkg::STATUS_BAD;
                  rsp_data_in.frame_length   = {{(LW-SW){1'b0}}, dlen};
                  rsp_data_in.payload_offset = next_pos[LW-1:0] -
                                               {{(LW-SW){1'b0}}, dlen};
                  rsp_data_in.last_of_psdu   = last;
                  phase_in = last ? PH_IDLE : PH_DELIM;
                  if (!last) begin
                     didx_in  = '0;
                     dbits_in = '0;
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end

      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         fmt_ff    <= fmt_in;
         rate_ff   <= rate_in;
         didx_ff   <= didx_in;
         dbits_ff  <= dbits_in;
         remain_ff <= remain_in;
         eof_ff    <= eof_in;
         crc_ff    <= crc_in;
      end
      if (accept && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_body_remain: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (remain_ff != '0))
      else $error("body phase with nothing left to count");

   a_delim_room: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DELIM) |-> ({1'b0, len_ff} >= pdcc_pkg::DELIM_BYTES))
      else $error("delimiter phase in a PSDU too short for a delimiter");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("held result was dropped or overwritten");

   a_aggr_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.first_byte && req_data.aggregated &&
       req_data.frame_format != pdcc_pkg::FMT_VHT) |=> (phase_ff == PH_IDLE && !rsp_valid_ff))
      else $error("aggregated non-VHT PSDU was not ignored");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench: streams PSDU bytes into the deaggregator and checks each verdict against a predictor.
module tb_top;

   localparam logic [1:0] FMT_UNDEFINED = 2'd3;

   typedef enum logic [1:0] {PARSE_IDLE, PARSE_WHOLE, PARSE_DELIM, PARSE_BODY} parse_phase_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   pdcc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   pdcc_pkg::rsp_type rsp_data;

   psdu_deaggregation_crc_check i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // stimulus and expectations
   pdcc_pkg::req_type stim_q[$];
   bit                hold_q[$];
   pdcc_pkg::rsp_type pending_verdicts[$];
   logic [7:0]        frame_octets[$];
   bit                drain_next = 1'b0;
   int                stim_total = 0;
   int                ignored_items = 0;
   int                psdu_starts = 0;
   int                bytes_accepted = 0;
   int                burst_left = 1;
   int                gap_left = 0;
   int                rx_cycle = 0;
   int                mismatches = 0;
   int                results_seen = 0;
   int                good_seen = 0;
   int                bad_seen = 0;
   int                rate_seen = 0;

   // parser predictor state
   parse_phase_type            parse_state = PARSE_IDLE;
   logic [pdcc_pkg::LEN_W-1:0] octet_pos = '0;
   logic [pdcc_pkg::LEN_W-1:0] psdu_len_q = '0;
   logic [1:0]                 fmt_q = '0;
   logic [3:0]                 rate_q = '0;
   logic                       agg_q = 1'b0;
   logic [1:0]                 delim_idx = '0;
   logic [23:0]                delim_word = '0;
   logic [pdcc_pkg::SUB_W-1:0] body_left = '0;
   logic                       eof_seen = 1'b0;
   logic [pdcc_pkg::CRC_W-1:0] fcs_reg = pdcc_pkg::CRC_PRESET;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [pdcc_pkg::CRC_W-1:0] crc_next(
      input logic [pdcc_pkg::CRC_W-1:0] c, input logic [7:0] d);
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ ((c[0] ^ d[k]) ? pdcc_pkg::CRC_POLY : '0);
      end
      return c;
   endfunction

   function automatic logic [pdcc_pkg::SUB_W-1:0] subframe_len();
      return {delim_word[3:2], delim_word[15:4]};
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 25) begin
         $display("%0t mismatch: %s", $time, what);
      end
   endtask

   task automatic queue_verdict(input logic [1:0] st, input logic [pdcc_pkg::LEN_W-1:0] len,
                                input logic [pdcc_pkg::LEN_W-1:0] off, input logic last);
      pdcc_pkg::rsp_type v;
      v.status         = st;
      v.frame_length   = len;
      v.payload_offset = off;
      v.last_of_psdu   = last;
      pending_verdicts.push_back(v);
   endtask

   task automatic close_subframe(input logic [1:0] st, input logic [pdcc_pkg::LEN_W-1:0] len,
                                 input logic [pdcc_pkg::LEN_W-1:0] off);
      int unsigned nxt;
      logic        last;
      nxt = octet_pos + 32'd1;
      last = 1'b0;
      if (eof_seen || nxt > psdu_len_q || psdu_len_q - nxt < 4) begin
         last = 1'b1;
         parse_state = PARSE_IDLE;
      end else begin
         parse_state = PARSE_DELIM;
         delim_idx = '0;
         delim_word = '0;
      end
      queue_verdict(st, len, off, last);
   endtask

   task automatic advance_parser(input pdcc_pkg::req_type r);
      int unsigned len;
      int unsigned body;
      logic [1:0]  st;
      logic [1:0]  i;
      if (r.first_byte) begin
         psdu_len_q = r.psdu_length;
         fmt_q = r.frame_format;
         rate_q = r.rate_index;
         agg_q = r.aggregated;
         octet_pos = '0;
         fcs_reg = pdcc_pkg::CRC_PRESET;
         eof_seen = 1'b0;
         delim_idx = '0;
         delim_word = '0;
         body_left = '0;
         if (fmt_q == pdcc_pkg::FMT_VHT) begin
            if (psdu_len_q < 4) begin
               parse_state = PARSE_IDLE;
               return;
            end
            parse_state = PARSE_DELIM;
         end else if (agg_q) begin
            parse_state = PARSE_IDLE;
            return;
         end else if (psdu_len_q == 0) begin
            parse_state = PARSE_IDLE;
            queue_verdict(pdcc_pkg::STATUS_BAD, '0, '0, 1'b1);
            return;
         end else begin
            parse_state = PARSE_WHOLE;
         end
      end else begin
         if (parse_state == PARSE_IDLE) return;
         octet_pos = octet_pos + 1'b1;
      end

      case (parse_state)
         PARSE_WHOLE: begin
            fcs_reg = crc_next(fcs_reg, r.data_byte);
            if (octet_pos + 32'd1 >= psdu_len_q) begin
               parse_state = PARSE_IDLE;
               if (~fcs_reg != pdcc_pkg::CRC_RESIDUE) st = pdcc_pkg::STATUS_BAD;
               // every 4-bit HT index is in range
               else if ((fmt_q == pdcc_pkg::FMT_LEGACY &&
                         rate_q < pdcc_pkg::LEGACY_RATE_LIMIT) ||
                        fmt_q == pdcc_pkg::FMT_HT)
                  st = pdcc_pkg::STATUS_GOOD;
               else st = pdcc_pkg::STATUS_RATE;
               queue_verdict(st, psdu_len_q, '0, 1'b1);
            end
         end
         PARSE_DELIM: begin
            i = delim_idx;
            if (i != 2'd3) delim_word[8*i +: 8] = delim_word[8*i +: 8] | r.data_byte;
            delim_idx = i + 2'd1;
            if (i == 2'd3) begin
               len = subframe_len();
               body = octet_pos + 32'd1;
               eof_seen = delim_word[0];
               if (body + len > psdu_len_q) begin
                  parse_state = PARSE_IDLE;
                  return;
               end
               fcs_reg = pdcc_pkg::CRC_PRESET;
               if (len == 0) begin
                  close_subframe(pdcc_pkg::STATUS_BAD, '0, pdcc_pkg::LEN_W'(body));
               end else begin
                  body_left = pdcc_pkg::SUB_W'(len);
                  parse_state = PARSE_BODY;
               end
            end
         end
         PARSE_BODY: begin
            fcs_reg = crc_next(fcs_reg, r.data_byte);
            body_left = body_left - 1'b1;
            if (body_left == 0) begin
               len = subframe_len();
               close_subframe((~fcs_reg == pdcc_pkg::CRC_RESIDUE) ?
                              pdcc_pkg::STATUS_GOOD : pdcc_pkg::STATUS_BAD,
                              pdcc_pkg::LEN_W'(len),
                              pdcc_pkg::LEN_W'(octet_pos + 32'd1 - len));
            end
         end
         default: begin
         end
      endcase
   endtask

   // n bytes; from 4 bytes on, the last 4 carry the FCS of the rest
   task automatic add_mpdu(input int n, input bit good);
      logic [pdcc_pkg::CRC_W-1:0] c;
      logic [7:0]                 d;
      int                         base;
      int                         idx;
      base = frame_octets.size();
      c = pdcc_pkg::CRC_PRESET;
      for (int k = 0; k < n; k++) begin
         if (n >= 4 && k >= n - 4) begin
            d = ~c[8*(k-n+4) +: 8];
         end else begin
            d = 8'($urandom);
            c = crc_next(c, d);
         end
         frame_octets.push_back(d);
      end
      if (!good && n > 0) begin
         idx = base + int'($urandom_range(n - 1));
         frame_octets[idx] = frame_octets[idx] ^ 8'(1 << $urandom_range(7));
      end
   endtask

   task automatic add_delim(input logic [pdcc_pkg::SUB_W-1:0] len, input logic eof);
      frame_octets.push_back({len[3:0], len[13:12], 1'($urandom), eof});
      frame_octets.push_back(len[11:4]);
      frame_octets.push_back(8'($urandom));
      frame_octets.push_back(8'($urandom));
   endtask

   task automatic queue_psdu(input logic lead, input logic [1:0] fmt, input logic [3:0] rate,
                             input logic agg, input logic [pdcc_pkg::LEN_W-1:0] len);
      pdcc_pkg::req_type r;
      foreach (frame_octets[k]) begin
         r.data_byte    = frame_octets[k];
         r.first_byte   = lead && (k == 0);
         r.psdu_length  = r.first_byte ? len : pdcc_pkg::LEN_W'($urandom);
         r.frame_format = r.first_byte ? fmt : 2'($urandom);
         r.rate_index   = r.first_byte ? rate : 4'($urandom);
         r.aggregated   = r.first_byte ? agg : 1'($urandom);
         stim_q.push_back(r);
         hold_q.push_back(drain_next);
         drain_next = 1'b0;
      end
      if (lead) psdu_starts++;
      frame_octets.delete();
   endtask

   // driver
   always @(posedge clock) begin
      logic send;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            advance_parser(req_data);
            bytes_accepted++;
         end
         send = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
         end else if (stim_q.size() != 0 && !(hold_q[0] && pending_verdicts.size() != 0)) begin
            send = 1'b1;
         end
         if (send) begin
            req_data <= stim_q.pop_front();
            void'(hold_q.pop_front());
            if (burst_left > 1) begin
               burst_left--;
            end else if ($urandom_range(5) == 0) begin
               burst_left = $urandom_range(120, 40);
               gap_left = 0;
            end else begin
               burst_left = $urandom_range(8, 1);
               gap_left = $urandom_range(1) ? $urandom_range(3, 1) : $urandom_range(14, 4);
            end
         end
         req_valid <= send;
      end
   end

   // monitor
   always @(posedge clock) begin
      pdcc_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               report_mismatch($sformatf("unexpected result status %0d length %0d offset %0d",
                                         rsp_data.status, rsp_data.frame_length,
                                         rsp_data.payload_offset));
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_data.status != want.status)
                  report_mismatch($sformatf("result %0d status %0d, want %0d",
                                            results_seen, rsp_data.status, want.status));
               if (rsp_data.frame_length != want.frame_length)
                  report_mismatch($sformatf("result %0d frame_length %0d, want %0d",
                                            results_seen, rsp_data.frame_length,
                                            want.frame_length));
               if (rsp_data.payload_offset != want.payload_offset)
                  report_mismatch($sformatf("result %0d payload_offset %0d, want %0d",
                                            results_seen, rsp_data.payload_offset,
                                            want.payload_offset));
               if (rsp_data.last_of_psdu != want.last_of_psdu)
                  report_mismatch($sformatf("result %0d last_of_psdu %0d, want %0d",
                                            results_seen, rsp_data.last_of_psdu,
                                            want.last_of_psdu));
               if (want.status == pdcc_pkg::STATUS_GOOD) good_seen++;
               else if (want.status == pdcc_pkg::STATUS_BAD) bad_seen++;
               else rate_seen++;
            end
            results_seen++;
         end
         rx_cycle++;
         case ((rx_cycle / 512) % 4)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(1) == 1);
            2: rsp_ready <= ($urandom_range(7) == 0);
            default: rsp_ready <= (rx_cycle % 11) > 3;
         endcase
      end
   end

   initial begin
      #5_000_000;
      $display("[psdu_deaggregation_crc_check] ERROR");
      $finish;
   end

   initial begin
      int         n;
      int         nsub;
      int         sel;
      int         plen;
      int         next_drain;
      bit         eof_end;
      logic [1:0] fmt;

      // directed: stray byte, empty legacy, bad rates, aggregated HT, short VHT,
      // zero-length subframe then overrun, restart of a maximum-length PSDU
      frame_octets.push_back(8'hA5);
      queue_psdu(1'b0, pdcc_pkg::FMT_LEGACY, 4'd0, 1'b0, '0);
      frame_octets.push_back(8'hFF);
      queue_psdu(1'b1, pdcc_pkg::FMT_LEGACY, 4'd0, 1'b0, 22'd0);
      add_mpdu(5, 1'b1);
      queue_psdu(1'b1, pdcc_pkg::FMT_LEGACY, pdcc_pkg::LEGACY_RATE_LIMIT + 4'd1, 1'b0, 22'd5);
      add_mpdu(4, 1'b1);
      queue_psdu(1'b1, FMT_UNDEFINED, 4'd3, 1'b0, 22'd4);
      add_mpdu(2, 1'b1);
      queue_psdu(1'b1, pdcc_pkg::FMT_HT, 4'd2, 1'b1, 22'd2);
      frame_octets.push_back(8'h00);
      queue_psdu(1'b1, pdcc_pkg::FMT_VHT, 4'd0, 1'b0, 22'd3);
      add_delim(14'd0, 1'b0);
      add_delim(14'h3FFF, 1'b1);
      queue_psdu(1'b1, pdcc_pkg::FMT_VHT, 4'hF, 1'b1, 22'd8);
      frame_octets.push_back(8'h00);
      frame_octets.push_back(8'hFF);
      queue_psdu(1'b1, pdcc_pkg::FMT_HT, 4'hF, 1'b0, 22'h3F_FFFF);

      drain_next = 1'b1;
      next_drain = stim_q.size() + 400;
      while (stim_q.size() - ignored_items < 1650) begin
         if (stim_q.size() >= next_drain) begin
            drain_next = 1'b1;
            next_drain += 400;
         end
         sel = $urandom_range(99);
         if (sel < 45) begin
            // A-MPDU with random content
            nsub = $urandom_range(4, 1);
            eof_end = $urandom_range(9) < 7;
            for (int s = 0; s < nsub; s++) begin
               sel = $urandom_range(9);
               n = (sel == 0) ? $urandom_range(3) :
                   (sel == 1) ? $urandom_range(80, 40) : $urandom_range(24, 4);
               add_delim(pdcc_pkg::SUB_W'(n), (s == nsub - 1) && eof_end);
               add_mpdu(n, $urandom_range(9) != 0);
               if (s < nsub - 1 && $urandom_range(9) == 0)
                  repeat ($urandom_range(3, 1)) frame_octets.push_back(8'($urandom));
            end
            if ($urandom_range(7) == 0)
               repeat ($urandom_range(5, 1)) frame_octets.push_back(8'($urandom));
            plen = frame_octets.size();
            if ($urandom_range(5) == 0) plen = plen + int'($urandom_range(6)) - 3;
            queue_psdu(1'b1, pdcc_pkg::FMT_VHT, 4'($urandom), 1'($urandom),
                       pdcc_pkg::LEN_W'(plen));
         end else if (sel < 80) begin
            // single-FCS PSDU
            n = ($urandom_range(9) == 0) ? $urandom_range(3) : $urandom_range(40, 4);
            add_mpdu(n, $urandom_range(7) != 0);
            if (n == 0) frame_octets.push_back(8'($urandom));
            sel = $urandom_range(9);
            fmt = (sel < 5) ? pdcc_pkg::FMT_LEGACY : (sel < 9) ? pdcc_pkg::FMT_HT : FMT_UNDEFINED;
            queue_psdu(1'b1, fmt, 4'($urandom), 1'b0, pdcc_pkg::LEN_W'(n));
         end else if (sel < 86) begin
            n = $urandom_range(10, 1);
            repeat (n) frame_octets.push_back(8'($urandom));
            sel = $urandom_range(9);
            fmt = (sel < 4) ? pdcc_pkg::FMT_LEGACY : (sel < 8) ? pdcc_pkg::FMT_HT : FMT_UNDEFINED;
            queue_psdu(1'b1, fmt, 4'($urandom), 1'b1,
                       $urandom_range(1) ? pdcc_pkg::LEN_W'($urandom) :
                                           pdcc_pkg::LEN_W'($urandom_range(12)));
            ignored_items += n;
         end else if (sel < 91) begin
            // long PSDU cut short by the next start
            repeat ($urandom_range(8, 1)) frame_octets.push_back(8'($urandom));
            queue_psdu(1'b1, 2'($urandom), 4'($urandom), 1'b0, pdcc_pkg::LEN_W'($urandom));
         end else if (sel < 95) begin
            add_delim(pdcc_pkg::SUB_W'($urandom), 1'($urandom));
            repeat ($urandom_range(6, 1)) frame_octets.push_back(8'($urandom));
            queue_psdu(1'b1, pdcc_pkg::FMT_VHT, 4'($urandom), 1'b0,
                       pdcc_pkg::LEN_W'($urandom));
         end else begin
            n = $urandom_range(3, 1);
            repeat (n) frame_octets.push_back(8'($urandom));
            queue_psdu(1'b0, pdcc_pkg::FMT_LEGACY, 4'd0, 1'b0, '0);
            ignored_items += n;
         end
      end
      stim_total = stim_q.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (bytes_accepted < stim_total) @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d byte transfers over %0d PSDU starts, %0d results checked",
               bytes_accepted, psdu_starts, results_seen);
      $display("verdicts: %0d FCS good, %0d FCS bad, %0d rate flagged",
               good_seen, bad_seen, rate_seen);
      if (mismatches == 0) begin
         $display("[psdu_deaggregation_crc_check] OK");
      end else begin
         $display("[psdu_deaggregation_crc_check] ERROR");
      end
      $finish;
   end

endmodule
